// ===== hw/rtl/lps_pkg.sv =====
// Shared types, constants and pattern ROM of the LED pattern sequencer.
package lps_pkg;

    localparam int LED_COUNT_DEF = 8;

    localparam logic [7:0]  PROG_VALID   = 8'd10;
    localparam logic [4:0]  PATTERN_BITS = 5'd24;
    localparam logic [6:0]  REP_FOREVER  = 7'h7F;
    localparam logic [1:0]  LAST_STEP    = 2'd2;
    localparam logic [31:0] PAD          = 32'hFE000000;
    localparam logic [7:0]  TOP_JUMP     = 8'h80;
    localparam logic [7:0]  TOP_PROGCHG  = 8'h81;
    localparam logic [6:0]  TOP_RETURN   = 7'h7F;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STEP,
        ST_DONE
    } lps_state_t;

    typedef struct packed {
        logic [3:0] prog;
        logic [3:0] word_index;
        logic [4:0] bits_left;
        logic [6:0] repeats_left;
    } led_entry_t;

    typedef struct packed {
        led_entry_t entry;
        logic       running;
        logic       again;
        logic       level;
    } step_res_t;

    function automatic logic [31:0] rom_word(input logic [3:0] prog, input logic [3:0] idx);
        logic [31:0] w;
        w = PAD;
        unique case (prog)
            4'd1:
            begin
                if (idx == 4'd0) w = 32'h7F111111;
            end
            4'd2:
            begin
                if (idx == 4'd0) w = 32'h7F555555;
            end
            4'd3:
            begin
                if (idx == 4'd0) w = 32'hFF000000;
            end
            4'd5:
            begin
                unique case (idx)
                    4'd0: w = 32'h02100183;
                    4'd1: w = 32'h03003FFF;
                    4'd2: w = 32'h01C00200;
                    4'd3: w = 32'h02AAAAAA;
                    4'd4: w = 32'h06FFFFFF;
                    4'd5: w = 32'h01AAAAFE;
                    4'd6: w = 32'hFF000000;
                    default: w = PAD;
                endcase
            end
            4'd6:
            begin
                unique case (idx)
                    4'd0: w = 32'h02100183;
                    4'd1: w = 32'h03003FFF;
                    4'd2: w = 32'h01C00200;
                    4'd3: w = 32'h02AAAAAA;
                    4'd4: w = 32'h00FFFFF0;
                    4'd5: w = 32'h003FF0CF;
                    4'd6: w = 32'h00ABF7FE;
                    4'd7: w = 32'hFF000000;
                    default: w = PAD;
                endcase
            end
            4'd7:
            begin
                unique case (idx)
                    4'd0: w = 32'h01EEEEEE;
                    4'd1: w = 32'h01DB6DB6;
                    4'd2: w = 32'h01CCCCCC;
                    4'd3: w = 32'h00111111;
                    default: w = PAD;
                endcase
            end
            4'd8:
            begin
                unique case (idx)
                    4'd0: w = 32'h00111111;
                    4'd1: w = 32'h01CCCCCC;
                    4'd2: w = 32'h01DB6DB6;
                    4'd3: w = 32'h01EEEEEE;
                    4'd4: w = 32'hFF000000;
                    default: w = PAD;
                endcase
            end
            4'd9:
            begin
                unique case (idx)
                    4'd0: w = 32'h00111111;
                    4'd1: w = 32'h00CCCCCC;
                    4'd2: w = 32'h00EEEEEE;
                    4'd3: w = 32'h00FFFFFF;
                    4'd4: w = 32'h00EEEEEE;
                    4'd5: w = 32'h00CCCCCC;
                    4'd6: w = 32'h00111111;
                    4'd7: w = 32'h01000000;
                    4'd8: w = 32'h80000000;
                    default: w = PAD;
                endcase
            end
            default: w = PAD;
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/lps_if.sv =====
// Item channel interfaces of the LED pattern sequencer.
interface lps_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [2:0] led_index;
    logic [7:0] program_number;

    modport source (output valid, output opcode, output led_index, output program_number,
                    input ready);
    modport sink (input valid, input opcode, input led_index, input program_number,
                  output ready);
endinterface

interface lps_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] drive_mask;
    logic [7:0] drive_levels;
    logic       fault;

    modport source (output valid, output drive_mask, output drive_levels, output fault,
                    input ready);
    modport sink (input valid, input drive_mask, input drive_levels, input fault,
                  output ready);
endinterface

// ===== hw/rtl/lps_led_mem.sv =====
// Per-LED state memory, one write port and one registered read port.
module lps_led_mem #(
    parameter int DEPTH = lps_pkg::LED_COUNT_DEF,
    parameter int AW    = 3
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output lps_pkg::led_entry_t rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  lps_pkg::led_entry_t wr_data
);

    lps_pkg::led_entry_t mem [DEPTH];
    lps_pkg::led_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/lps_step.sv =====
// One interpreter step of a running LED: fetch word, decode, update entry.
module lps_step (
    input  lps_pkg::led_entry_t entry,
    output lps_pkg::step_res_t  res
);

    always_comb
    begin
        logic [31:0] w;
        logic [7:0]  top;
        logic [4:0]  b;
        w   = lps_pkg::rom_word(entry.prog, entry.word_index);
        top = w[31:24];
        b   = entry.bits_left - 5'd1;
        res         = '0;
        res.entry   = entry;
        res.running = 1'b1;
        priority if (entry.bits_left != 5'd0)
        begin
            res.entry.bits_left = b;
            if (b == 5'd0)
            begin
                if (entry.repeats_left == 7'd0)
                begin
                    res.entry.word_index = entry.word_index + 4'd1;
                end
                else
                begin
                    if (entry.repeats_left != lps_pkg::REP_FOREVER)
                    begin
                        res.entry.repeats_left = entry.repeats_left - 7'd1;
                    end
                    res.entry.bits_left = lps_pkg::PATTERN_BITS;
                end
            end
            res.level = w[b];
        end
        else if (!top[7])
        begin
            res.entry.bits_left    = lps_pkg::PATTERN_BITS;
            res.entry.repeats_left = top[6:0];
            res.again              = 1'b1;
        end
        else if (top == lps_pkg::TOP_JUMP)
        begin
            res.entry.word_index = w[3:0];
            res.again            = 1'b1;
        end
        else if (top == lps_pkg::TOP_PROGCHG)
        begin
            res.entry.word_index   = 4'd0;
            res.entry.bits_left    = 5'd0;
            res.entry.repeats_left = 7'd0;
            if (w[7:0] < lps_pkg::PROG_VALID)
            begin
                res.entry.prog = w[3:0];
                res.again      = 1'b1;
            end
            else
            begin
                res.running = 1'b0;
            end
        end
        else if (top[7:1] == lps_pkg::TOP_RETURN)
        begin
            res.running          = 1'b0;
            res.entry.word_index = 4'd0;
            res.level            = top[0];
        end
        else
        begin
            res.entry.word_index = entry.word_index + 4'd1;
        end
    end

endmodule

// ===== hw/rtl/led_pattern_bytecode_sequencer_unit.sv =====
// Top level of the LED pattern sequencer: command decode, LED scan and result register.
// A command item is taken when the unit is idle. Start and clear items, unused opcodes
// and a tick that applies a pending clear go from accept straight to the result load.
// Any other tick is accepted, then per LED passes one scan step plus one to three
// interpreter steps when the LED is running, then loads the result once the output
// register is free. The scan time is set by the single per-LED state memory, read
// once and written once per running LED, and the one shared step unit that follows
// at most three words per LED and tick. A result waits in an output register, so the
// next item is accepted while it is still pending. Running flags sit in flip-flops and
// are cleared at reset, so no memory clearing pass is needed.
module led_pattern_bytecode_sequencer_unit #(
    parameter int LED_COUNT = lps_pkg::LED_COUNT_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    lps_cmd_if.sink   cmd,
    lps_res_if.source result
);

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    lps_pkg::lps_state_t state_reg, state_next;
    logic [IDX_W-1:0]     i_reg, i_next;
    logic [1:0]           n_reg, n_next;
    logic [LED_COUNT-1:0] running_reg, running_next;
    logic                 clear_pending_reg, clear_pending_next;
    lps_pkg::led_entry_t  work_reg, work_next;
    logic [7:0]           acc_mask_reg, acc_mask_next;
    logic [7:0]           acc_lev_reg, acc_lev_next;
    logic                 acc_fault_reg, acc_fault_next;
    logic                 res_valid_reg, res_valid_next;
    logic [7:0]           res_mask_reg, res_mask_next;
    logic [7:0]           res_lev_reg, res_lev_next;
    logic                 res_fault_reg, res_fault_next;

    logic                 cmd_fire;
    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    lps_pkg::led_entry_t  wr_data;
    lps_pkg::led_entry_t  rd_data;
    lps_pkg::led_entry_t  step_in;
    lps_pkg::step_res_t   step_out;
    logic [IDX_W+2:0]     idx_wide;
    logic [IDX_W+2:0]     i_wide;
    logic                 idx_ok;
    logic                 i_last;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign idx_wide = (IDX_W+3)'(cmd.led_index);
    assign i_wide   = (IDX_W+3)'(i_reg);
    assign idx_ok   = 32'(cmd.led_index) < 32'(LED_COUNT);
    assign i_last   = i_reg == IDX_W'(LED_COUNT - 1);
    assign step_in  = (n_reg == 2'd0) ? rd_data : work_reg;

    lps_led_mem #(
        .DEPTH (LED_COUNT),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (i_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lps_step u_step (
        .entry (step_in),
        .res   (step_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= lps_pkg::ST_IDLE;
            i_reg             <= '0;
            n_reg             <= '0;
            running_reg       <= '0;
            clear_pending_reg <= 1'b1;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            i_reg             <= i_next;
            n_reg             <= n_next;
            running_reg       <= running_next;
            clear_pending_reg <= clear_pending_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        acc_mask_reg  <= acc_mask_next;
        acc_lev_reg   <= acc_lev_next;
        acc_fault_reg <= acc_fault_next;
        res_mask_reg  <= res_mask_next;
        res_lev_reg   <= res_lev_next;
        res_fault_reg <= res_fault_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        i_next             = i_reg;
        n_next             = n_reg;
        running_next       = running_reg;
        clear_pending_next = clear_pending_reg;
        work_next          = work_reg;
        acc_mask_next      = acc_mask_reg;
        acc_lev_next       = acc_lev_reg;
        acc_fault_next     = acc_fault_reg;
        res_valid_next     = res_valid_reg && !result.ready;
        res_mask_next      = res_mask_reg;
        res_lev_next       = res_lev_reg;
        res_fault_next     = res_fault_reg;
        cmd.ready          = state_reg == lps_pkg::ST_IDLE;
        rd_en              = 1'b0;
        wr_en              = 1'b0;
        wr_addr            = i_reg;
        wr_data            = step_out.entry;

        unique case (state_reg)
            lps_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    acc_mask_next  = '0;
                    acc_lev_next   = '0;
                    acc_fault_next = 1'b0;
                    state_next     = lps_pkg::ST_DONE;
                    unique case (cmd.opcode)
                        lps_pkg::OP_START:
                        begin
                            if (idx_ok)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = idx_wide[IDX_W-1:0];
                                wr_data = '{prog: cmd.program_number[3:0], word_index: 4'd0,
                                            bits_left: 5'd0, repeats_left: 7'd0};
                                running_next[idx_wide[IDX_W-1:0]] =
                                    cmd.program_number < lps_pkg::PROG_VALID;
                            end
                        end
                        lps_pkg::OP_CLEAR:
                        begin
                            clear_pending_next = 1'b1;
                        end
                        lps_pkg::OP_TICK:
                        begin
                            if (clear_pending_reg)
                            begin
                                clear_pending_next = 1'b0;
                                running_next       = '0;
                            end
                            else
                            begin
                                i_next     = '0;
                                state_next = lps_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lps_pkg::ST_SCAN:
            begin
                if (running_reg[i_reg])
                begin
                    rd_en      = 1'b1;
                    n_next     = 2'd0;
                    state_next = lps_pkg::ST_STEP;
                end
                else if (i_last)
                begin
                    state_next = lps_pkg::ST_DONE;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            lps_pkg::ST_STEP:
            begin
                if (!step_out.again || n_reg == lps_pkg::LAST_STEP)
                begin
                    wr_en                = 1'b1;
                    running_next[i_reg]  = step_out.running;
                    if (i_wide < (IDX_W+3)'(8))
                    begin
                        acc_mask_next[i_wide[2:0]] = 1'b1;
                        acc_lev_next[i_wide[2:0]]  = step_out.level && !step_out.again;
                    end
                    if (step_out.again)
                    begin
                        acc_fault_next = 1'b1;
                    end
                    n_next = 2'd0;
                    if (i_last)
                    begin
                        state_next = lps_pkg::ST_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = lps_pkg::ST_SCAN;
                    end
                end
                else
                begin
                    work_next = step_out.entry;
                    n_next    = n_reg + 2'd1;
                end
            end
            lps_pkg::ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_mask_next  = acc_mask_reg;
                    res_lev_next   = acc_lev_reg;
                    res_fault_next = acc_fault_reg;
                    state_next     = lps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lps_pkg::ST_IDLE;
            end
        endcase
    end

    assign result.valid        = res_valid_reg;
    assign result.drive_mask   = res_mask_reg;
    assign result.drive_levels = res_lev_reg;
    assign result.fault        = res_fault_reg;

`ifndef SYNTHESIS
    a_step_on_running: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lps_pkg::ST_STEP |-> running_reg[i_reg])
        else $error("step on an idle LED");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lps_pkg::ST_STEP |-> n_reg != 2'd3)
        else $error("step count past limit");

    a_clear_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.opcode == lps_pkg::OP_TICK && clear_pending_reg)
        |=> (running_reg == '0 && !clear_pending_reg))
        else $error("pending clear not applied on tick");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == lps_pkg::ST_DONE)
        else $error("result loaded outside done state");
`endif

endmodule

// ===== tb/sv/tb_led_pattern_bytecode_sequencer_unit.sv =====
// Self-checking testbench of the LED pattern sequencer: directed and random item traffic against a predictor.
`timescale 1ns / 100ps

module tb_led_pattern_bytecode_sequencer_unit;

    localparam int          LEDS        = 8;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PHASE_ITEMS = 125;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [31:0] RET_LOW     = 32'hFE000000;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] led_index;
        logic [7:0] program_number;
    } seq_cmd_t;

    typedef struct packed {
        logic [7:0] drive_mask;
        logic [7:0] drive_levels;
        logic       fault;
    } seq_res_t;

    logic clk;
    logic rst_n;

    lps_cmd_if cmd_ch ();
    lps_res_if res_ch ();

    led_pattern_bytecode_sequencer_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    // predictor state
    logic [31:0] pattern_rom [0:9][0:15];
    logic [3:0]  led_prog [LEDS];
    logic        led_on   [LEDS];
    logic [3:0]  led_widx [LEDS];
    logic [4:0]  led_bits [LEDS];
    logic [6:0]  led_reps [LEDS];
    logic        clear_armed;

    seq_cmd_t cmd_backlog [$];
    seq_res_t drive_expect [$];

    int sender_idle_pct;
    int recv_stall_pct;
    logic hold_go;
    logic hold_done;
    int hold_left;

    int n_pushed;
    int n_checked;
    int n_errors;
    int n_ticks;
    int n_starts;
    int n_clears;
    int n_ignored;
    int n_drives;
    int n_high;
    int n_faults;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic logic [31:0] pattern_word(input logic [3:0] prog, input logic [3:0] idx);
        if (prog < lps_pkg::PROG_VALID)
            return pattern_rom[prog][idx];
        return RET_LOW;
    endfunction

    function automatic void idle_led(input int i);
        led_on[i]   = 1'b0;
        led_widx[i] = 4'd0;
        led_bits[i] = 5'd0;
        led_reps[i] = 7'd0;
    endfunction

    // one interpreter step; returns 1 when the LED needs another word this tick
    function automatic logic advance_led(input int i, output logic lvl);
        logic [31:0] w;
        logic [7:0]  top;
        logic [7:0]  p;
        logic [4:0]  b;
        w   = pattern_word(led_prog[i], led_widx[i]);
        top = w[31:24];
        lvl = 1'b0;
        if (led_bits[i] != 5'd0)
        begin
            led_bits[i] = led_bits[i] - 5'd1;
            b = led_bits[i];
            if (b == 5'd0)
            begin
                if (led_reps[i] == 7'd0)
                    led_widx[i] = led_widx[i] + 4'd1;
                else
                begin
                    if (led_reps[i] != lps_pkg::REP_FOREVER)
                        led_reps[i] = led_reps[i] - 7'd1;
                    led_bits[i] = lps_pkg::PATTERN_BITS;
                end
            end
            lvl = w[b];
            return 1'b0;
        end
        if (!top[7])
        begin
            led_bits[i] = lps_pkg::PATTERN_BITS;
            led_reps[i] = top[6:0];
            return 1'b1;
        end
        if (top == lps_pkg::TOP_JUMP)
        begin
            led_widx[i] = w[3:0];
            return 1'b1;
        end
        if (top == lps_pkg::TOP_PROGCHG)
        begin
            p = w[7:0];
            idle_led(i);
            if (p < lps_pkg::PROG_VALID)
            begin
                led_prog[i] = p[3:0];
                led_on[i]   = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        if (top[7:1] == lps_pkg::TOP_RETURN)
        begin
            led_on[i]   = 1'b0;
            led_widx[i] = 4'd0;
            lvl = top[0];
            return 1'b0;
        end
        led_widx[i] = led_widx[i] + 4'd1;
        return 1'b0;
    endfunction

    function automatic seq_res_t predict_drive(input seq_cmd_t c);
        seq_res_t r;
        logic     lvl;
        logic     again;
        int       n;
        r = '0;
        case (c.opcode)
            lps_pkg::OP_START:
            begin
                idle_led(c.led_index);
                if (c.program_number < lps_pkg::PROG_VALID)
                begin
                    led_prog[c.led_index] = c.program_number[3:0];
                    led_on[c.led_index]   = 1'b1;
                end
            end
            lps_pkg::OP_CLEAR:
            begin
                clear_armed = 1'b1;
            end
            lps_pkg::OP_TICK:
            begin
                if (clear_armed)
                begin
                    clear_armed = 1'b0;
                    for (int i = 0; i < LEDS; i++)
                        idle_led(i);
                end
                for (int i = 0; i < LEDS; i++)
                begin
                    if (led_on[i])
                    begin
                        again = 1'b1;
                        lvl   = 1'b0;
                        n     = 0;
                        while (again && n < 3)
                        begin
                            again = advance_led(i, lvl);
                            n++;
                        end
                        if (again)
                        begin
                            r.fault = 1'b1;
                            lvl = 1'b0;
                        end
                        r.drive_mask[i]   = 1'b1;
                        r.drive_levels[i] = lvl;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic seq_cmd_t random_cmd();
        seq_cmd_t c;
        int       r;
        c.led_index      = 3'($urandom_range(0, 7));
        c.program_number = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 999);
        if (r < 860)
            c.opcode = lps_pkg::OP_TICK;
        else if (r < 940)
        begin
            c.opcode = lps_pkg::OP_START;
            // upper LEDs are restarted rarely so their programs run deep
            if ($urandom_range(0, 99) < 80)
                c.led_index = 3'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 75)
                c.program_number = 8'($urandom_range(0, 9));
        end
        else if (r < 943)
            c.opcode = lps_pkg::OP_CLEAR;
        else
            c.opcode = OP_UNUSED;
        return c;
    endfunction

    task automatic queue_cmd(input logic [1:0] op, input int led, input int prog);
        seq_cmd_t c;
        c.opcode         = op;
        c.led_index      = 3'(led);
        c.program_number = 8'(prog);
        cmd_backlog.push_back(c);
        n_pushed++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic     busy;
        seq_cmd_t c;
        seq_res_t e;
        if (!rst_n)
        begin
            cmd_ch.valid          <= 1'b0;
            cmd_ch.opcode         <= lps_pkg::OP_TICK;
            cmd_ch.led_index      <= 3'd0;
            cmd_ch.program_number <= 8'd0;
        end
        else
        begin
            busy = cmd_ch.valid;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                c.opcode         = cmd_ch.opcode;
                c.led_index      = cmd_ch.led_index;
                c.program_number = cmd_ch.program_number;
                e = predict_drive(c);
                drive_expect.push_back(e);
                case (c.opcode)
                    lps_pkg::OP_TICK:  n_ticks++;
                    lps_pkg::OP_START: n_starts++;
                    lps_pkg::OP_CLEAR: n_clears++;
                    default:  n_ignored++;
                endcase
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    c = cmd_backlog.pop_front();
                    cmd_ch.valid          <= 1'b1;
                    cmd_ch.opcode         <= c.opcode;
                    cmd_ch.led_index      <= c.led_index;
                    cmd_ch.program_number <= c.program_number;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        seq_res_t e;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (drive_expect.size() == 0)
                begin
                    $error("result with none expected: mask %h levels %h fault %b",
                           res_ch.drive_mask, res_ch.drive_levels, res_ch.fault);
                    n_errors++;
                end
                else
                begin
                    e = drive_expect.pop_front();
                    if (res_ch.drive_mask !== e.drive_mask)
                    begin
                        $error("drive_mask: expected %h, got %h", e.drive_mask,
                               res_ch.drive_mask);
                        n_errors++;
                    end
                    if (res_ch.drive_levels !== e.drive_levels)
                    begin
                        $error("drive_levels: expected %h, got %h", e.drive_levels,
                               res_ch.drive_levels);
                        n_errors++;
                    end
                    if (res_ch.fault !== e.fault)
                    begin
                        $error("fault: expected %b, got %b", e.fault, res_ch.fault);
                        n_errors++;
                    end
                    n_drives = n_drives + $countones(e.drive_mask);
                    n_high   = n_high + $countones(e.drive_levels);
                    if (e.fault)
                        n_faults++;
                end
                n_checked++;
            end
            res_ch.ready <= (hold_left == 0) && !(hold_go && !hold_done) &&
                            ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("led_pattern_bytecode_sequencer_unit test failed");
        $finish;
    end

    initial
    begin
        int       useful;
        seq_cmd_t c;
        rst_n                 = 1'b0;
        hold_go               = 1'b0;
        sender_idle_pct       = 0;
        recv_stall_pct        = 0;
        n_pushed  = 0;
        n_checked = 0;
        n_errors  = 0;
        n_ticks   = 0;
        n_starts  = 0;
        n_clears  = 0;
        n_ignored = 0;
        n_drives  = 0;
        n_high    = 0;
        n_faults  = 0;
        for (int p = 0; p < 10; p++)
            for (int i = 0; i < 16; i++)
                pattern_rom[p][i] = RET_LOW;
        pattern_rom[1][0] = 32'h7F111111;
        pattern_rom[2][0] = 32'h7F555555;
        pattern_rom[3][0] = 32'hFF000000;
        pattern_rom[5][0] = 32'h02100183;
        pattern_rom[5][1] = 32'h03003FFF;
        pattern_rom[5][2] = 32'h01C00200;
        pattern_rom[5][3] = 32'h02AAAAAA;
        pattern_rom[5][4] = 32'h06FFFFFF;
        pattern_rom[5][5] = 32'h01AAAAFE;
        pattern_rom[5][6] = 32'hFF000000;
        pattern_rom[6][0] = 32'h02100183;
        pattern_rom[6][1] = 32'h03003FFF;
        pattern_rom[6][2] = 32'h01C00200;
        pattern_rom[6][3] = 32'h02AAAAAA;
        pattern_rom[6][4] = 32'h00FFFFF0;
        pattern_rom[6][5] = 32'h003FF0CF;
        pattern_rom[6][6] = 32'h00ABF7FE;
        pattern_rom[6][7] = 32'hFF000000;
        pattern_rom[7][0] = 32'h01EEEEEE;
        pattern_rom[7][1] = 32'h01DB6DB6;
        pattern_rom[7][2] = 32'h01CCCCCC;
        pattern_rom[7][3] = 32'h00111111;
        pattern_rom[8][0] = 32'h00111111;
        pattern_rom[8][1] = 32'h01CCCCCC;
        pattern_rom[8][2] = 32'h01DB6DB6;
        pattern_rom[8][3] = 32'h01EEEEEE;
        pattern_rom[8][4] = 32'hFF000000;
        pattern_rom[9][0] = 32'h00111111;
        pattern_rom[9][1] = 32'h00CCCCCC;
        pattern_rom[9][2] = 32'h00EEEEEE;
        pattern_rom[9][3] = 32'h00FFFFFF;
        pattern_rom[9][4] = 32'h00EEEEEE;
        pattern_rom[9][5] = 32'h00CCCCCC;
        pattern_rom[9][6] = 32'h00111111;
        pattern_rom[9][7] = 32'h01000000;
        pattern_rom[9][8] = 32'h80000000;
        for (int i = 0; i < LEDS; i++)
        begin
            idle_led(i);
            led_prog[i] = 4'd0;
        end
        clear_armed = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // clear armed at reset: first tick drives nothing
        queue_cmd(lps_pkg::OP_TICK, 0, 0);
        queue_cmd(lps_pkg::OP_START, 0, 3);
        queue_cmd(lps_pkg::OP_START, 1, 0);
        queue_cmd(lps_pkg::OP_START, 2, 255);
        queue_cmd(lps_pkg::OP_START, 3, 10);
        queue_cmd(lps_pkg::OP_START, 4, 9);
        queue_cmd(lps_pkg::OP_START, 5, 7);
        queue_cmd(lps_pkg::OP_START, 6, 6);
        queue_cmd(lps_pkg::OP_START, 7, 5);
        queue_cmd(lps_pkg::OP_TICK, 7, 255);
        queue_cmd(lps_pkg::OP_TICK, 0, 0);
        queue_cmd(OP_UNUSED, 7, 255);
        queue_cmd(lps_pkg::OP_START, 0, 1);
        queue_cmd(lps_pkg::OP_START, 1, 2);
        queue_cmd(lps_pkg::OP_START, 2, 8);
        queue_cmd(lps_pkg::OP_TICK, 0, 0);
        queue_cmd(lps_pkg::OP_CLEAR, 5, 170);
        queue_cmd(lps_pkg::OP_START, 3, 4);
        queue_cmd(lps_pkg::OP_TICK, 2, 85);
        queue_cmd(lps_pkg::OP_START, 4, 9);
        queue_cmd(lps_pkg::OP_START, 5, 7);
        queue_cmd(lps_pkg::OP_START, 6, 6);
        queue_cmd(lps_pkg::OP_START, 7, 5);
        queue_cmd(lps_pkg::OP_START, 0, 1);
        queue_cmd(lps_pkg::OP_TICK, 0, 0);
        while (n_checked < n_pushed)
            @(posedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            @(posedge clk);
            case (phase)
                0:
                begin
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 0;
                    hold_go         <= 1'b1;
                end
                1:
                begin
                    sender_idle_pct <= 55;
                    recv_stall_pct  <= 0;
                end
                2:
                begin
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 55;
                end
                default:
                begin
                    sender_idle_pct <= 22;
                    recv_stall_pct  <= 22;
                end
            endcase
            useful = 0;
            while (useful < PHASE_ITEMS)
            begin
                c = random_cmd();
                queue_cmd(c.opcode, c.led_index, c.program_number);
                if (c.opcode != OP_UNUSED)
                    useful++;
            end
            while (n_checked < n_pushed)
                @(posedge clk);
        end

        repeat (40) @(posedge clk);
        while (drive_expect.size() > 0)
        begin
            c = '0;
            $error("expected result never arrived");
            n_errors++;
            void'(drive_expect.pop_front());
        end

        $display("%0d items: %0d ticks, %0d starts, %0d clears, %0d unused opcodes",
                 n_pushed, n_ticks, n_starts, n_clears, n_ignored);
        $display("%0d results checked, %0d LED drives (%0d high), %0d faults, %0d errors",
                 n_checked, n_drives, n_high, n_faults, n_errors);
        if (n_errors == 0)
            $display("led_pattern_bytecode_sequencer_unit test passed");
        else
            $display("led_pattern_bytecode_sequencer_unit test failed");
        $finish;
    end

endmodule
